// ----- rtl/mips_subset_single_cycle_core_macros.svh -----
// Assertion macros shared by the core's RTL files.
// Needs nothing else; define SYNTH to compile the checks out.
`ifndef MIPS_SUBSET_SINGLE_CYCLE_CORE_MACROS_SVH
`define MIPS_SUBSET_SINGLE_CYCLE_CORE_MACROS_SVH

`ifndef SYNTH

// Property must hold at every clock edge outside reset.
`define MSCC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("mips subset core: property violated");

// Condition must never be seen at a clock edge outside reset.
`define MSCC_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("mips subset core: forbidden condition seen");

`else

`define MSCC_ASSERT(label, clk, rst_n, prop)
`define MSCC_NEVER(label, clk, rst_n, cond)

`endif

`endif

// ----- rtl/mscc_pkg.sv -----
// Shared constants and types of the MIPS subset core.
// Used by the register file, the data memory and the top level.
package mscc_pkg;

    localparam int DATA_BYTES_DEF = 4096;
    localparam int BANKS          = 4;
    localparam int REG_COUNT      = 32;
    localparam int REG_AW         = 5;
    localparam int WORD_W         = 32;

    // item kinds carried in tuser
    localparam logic [1:0] OP_EXEC  = 2'd0;
    localparam logic [1:0] OP_BWR   = 2'd1;
    localparam logic [1:0] OP_BRD   = 2'd2;
    localparam logic [1:0] OP_RREG  = 2'd3;

    // primary opcodes
    localparam logic [5:0] OPC_RTYPE = 6'h00;
    localparam logic [5:0] OPC_J     = 6'h02;
    localparam logic [5:0] OPC_BEQ   = 6'h04;
    localparam logic [5:0] OPC_ADDIU = 6'h09;
    localparam logic [5:0] OPC_LW    = 6'h23;
    localparam logic [5:0] OPC_SW    = 6'h2b;

    // R-type selection by the low three funct bits
    localparam logic [2:0] FN_ADDU = 3'd1;
    localparam logic [2:0] FN_SUBU = 3'd3;
    localparam logic [2:0] FN_AND  = 3'd4;
    localparam logic [2:0] FN_OR   = 3'd5;
    localparam logic [2:0] FN_NOR  = 3'd7;

    localparam logic [31:0] HALT_WORD = 32'hffff_ffff;
    localparam logic [31:0] JUMP_MASK = 32'hf000_0000;

    typedef struct packed {
        logic              en;
        logic [REG_AW-1:0] addr;
        logic [WORD_W-1:0] data;
    } rf_wr_t;

endpackage

// ----- rtl/mips_subset_single_cycle_core.sv -----
// Top level of the MIPS subset core: decode/execute stage, memory stage
// and result register. Depends on mscc_pkg, mscc_regfile and mscc_dmem.
//
//  channel  dir  tdata fields (low bit up)                          tuser
//  s_*      in   instr, byte_addr, byte_value, reg_sel (57 of 64)   op
//  m_*      out  next_pc, halted, reg_wrote, dest_reg, dest_value,  -
//                mem_wrote, read_value (104 bits)
//
// One item per cycle sustained while m_tready is high; each item passes from
// accept to result through register-file read, data-memory read and result register.
// Register reads are issued as the item is accepted; the write of the item
// ahead is forwarded, including load data straight from the bank outputs.
// After reset the data memory is cleared one row of four bytes a cycle,
// all DATA_BYTES/4 rows (1024 by default); s_tready stays low meanwhile.
// A stalled result holds the pipeline back stage by stage, none dropped.
module mips_subset_single_cycle_core #(
    parameter int DATA_BYTES = mscc_pkg::DATA_BYTES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // instr, byte_addr, byte_value, reg_sel, zero pad
    input  logic [1:0]   s_tuser,   // op
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata    // next_pc, halted, reg_wrote, dest_reg, dest_value,
                                    // mem_wrote, read_value
);
    import mscc_pkg::*;

    `include "mips_subset_single_cycle_core_macros.svh"

    localparam int AW = $clog2(DATA_BYTES);
    localparam int RW = AW - 2;

    // input unpack
    logic [1:0]        in_op;
    logic [31:0]       in_instr;
    logic [11:0]       in_baddr;
    logic [7:0]        in_bval;
    logic [4:0]        in_rsel;

    logic              accept;
    logic              s1_adv;
    logic              s2_adv;
    logic              dm_busy;

    // architectural state kept here
    logic [31:0]       pc_reg;
    logic              halt_reg;

    // stage 1: register operands valid
    logic              s1_valid_reg;
    logic [1:0]        s1_op_reg;
    logic [31:0]       s1_instr_reg;
    logic [11:0]       s1_baddr_reg;
    logic [7:0]        s1_bval_reg;
    logic [4:0]        s1_ra_reg;
    logic [4:0]        s1_rb_reg;

    // stage 2: data-memory read valid
    logic              s2_valid_reg;
    logic [1:0]        s2_op_reg;
    logic              s2_reg_we_reg;
    logic [4:0]        s2_dest_reg;
    logic [31:0]       s2_alu_reg;
    logic              s2_load_reg;
    logic              s2_store_reg;
    logic [31:0]       s2_sdata_reg;
    logic [7:0]        s2_bval_reg;
    logic [1:0]        s2_off_reg;
    logic [BANKS-1:0][RW-1:0] s2_rows_reg;
    logic [31:0]       s2_npc_reg;
    logic              s2_halt_reg;
    logic [31:0]       s2_rdval_reg;

    // result register
    logic              m_valid_reg;
    logic [103:0]      m_data_reg;

    // regfile and memory hookup
    logic [4:0]        ra_next;
    logic [4:0]        rb_next;
    rf_wr_t            rf_wr;
    logic [31:0]       rf_a;
    logic [31:0]       rf_b;
    logic [BANKS-1:0][RW-1:0] dm_rrow_next;
    logic [BANKS-1:0]         dm_wr_en;
    logic [BANKS-1:0][RW-1:0] dm_wr_row;
    logic [BANKS-1:0][7:0]    dm_wr_data;
    logic [BANKS-1:0][7:0]    dm_rdata;

    // stage 1 logic
    logic [31:0]       op_a;
    logic [31:0]       op_b;
    logic              exec;
    logic              is_halt;
    logic [5:0]        opc;
    logic [31:0]       imm;
    logic [31:0]       pc4;
    logic [31:0]       eff;
    logic [31:0]       baddr_ext;
    logic [AW-1:0]     base;
    logic [BANKS-1:0][1:0]    bank_off;
    logic [BANKS-1:0][AW-1:0] bank_addr;
    logic [BANKS-1:0][RW-1:0] s1_rows;
    logic              we_next;
    logic [4:0]        dest_next;
    logic [31:0]       alu_next;
    logic              load_next;
    logic              store_next;
    logic [31:0]       npc_next;
    logic              halt_next;

    // stage 2 logic
    logic [3:0][7:0]   ld_bytes;
    logic [3:0][7:0]   sd_bytes;
    logic [1:0]        st_idx;
    logic [31:0]       s2_value;
    logic [31:0]       s2_rdval;

    assign in_instr = s_tdata[31:0];
    assign in_baddr = s_tdata[43:32];
    assign in_bval  = s_tdata[51:44];
    assign in_rsel  = s_tdata[56:52];
    assign in_op    = s_tuser;

    assign s2_adv   = s2_valid_reg && (!m_valid_reg || m_tready);
    assign s1_adv   = s1_valid_reg && (!s2_valid_reg || s2_adv);
    assign s_tready = !dm_busy && (!s1_valid_reg || s1_adv);
    assign accept   = s_tvalid && s_tready;

    // re-read the held item's registers unless a new one comes in
    assign ra_next = accept ? ((in_op == OP_RREG) ? in_rsel : in_instr[25:21]) : s1_ra_reg;
    assign rb_next = accept ? in_instr[20:16] : s1_rb_reg;

    mscc_regfile u_regfile (
        .clk     (clk),
        .rst_n   (rst_n),
        .ra_next (ra_next),
        .rb_next (rb_next),
        .wr      (rf_wr),
        .rdata_a (rf_a),
        .rdata_b (rf_b)
    );

    mscc_dmem #(.DATA_BYTES(DATA_BYTES)) u_dmem (
        .clk       (clk),
        .rst_n     (rst_n),
        .rrow_next (dm_rrow_next),
        .wr_en     (dm_wr_en),
        .wr_row    (dm_wr_row),
        .wr_data   (dm_wr_data),
        .rdata     (dm_rdata),
        .busy      (dm_busy)
    );

    // ---------------- stage 1: decode and execute ----------------
    always_comb
    begin
        if (s2_valid_reg && s2_reg_we_reg && s2_dest_reg == s1_ra_reg)
            op_a = s2_value;
        else
            op_a = rf_a;
        if (s2_valid_reg && s2_reg_we_reg && s2_dest_reg == s1_rb_reg)
            op_b = s2_value;
        else
            op_b = rf_b;

        exec    = (s1_op_reg == OP_EXEC) && !halt_reg;
        is_halt = exec && (s1_instr_reg == HALT_WORD);
        opc     = s1_instr_reg[31:26];
        imm     = {{16{s1_instr_reg[15]}}, s1_instr_reg[15:0]};
        pc4     = pc_reg + 32'd4;
        eff     = op_a + imm;

        we_next    = 1'b0;
        dest_next  = '0;
        alu_next   = '0;
        load_next  = 1'b0;
        store_next = 1'b0;
        npc_next   = pc_reg;
        halt_next  = halt_reg | is_halt;

        if (exec && !is_halt)
        begin
            npc_next = pc4;
            case (opc)
                OPC_RTYPE:
                begin
                    we_next   = 1'b1;
                    dest_next = s1_instr_reg[15:11];
                    case (s1_instr_reg[2:0])
                        FN_ADDU: alu_next = op_a + op_b;
                        FN_SUBU: alu_next = op_a - op_b;
                        FN_AND:  alu_next = op_a & op_b;
                        FN_OR:   alu_next = op_a | op_b;
                        FN_NOR:  alu_next = ~(op_a | op_b);
                        default: we_next  = 1'b0;
                    endcase
                end
                OPC_ADDIU:
                begin
                    we_next   = 1'b1;
                    dest_next = s1_instr_reg[20:16];
                    alu_next  = eff;
                end
                OPC_LW:
                begin
                    we_next   = 1'b1;
                    dest_next = s1_instr_reg[20:16];
                    load_next = 1'b1;
                end
                OPC_SW:
                begin
                    store_next = 1'b1;
                end
                OPC_BEQ:
                begin
                    if (op_a == op_b)
                        npc_next = pc4 + {imm[29:0], 2'b00};
                end
                OPC_J:
                begin
                    npc_next = (pc4 & JUMP_MASK) | {4'b0000, s1_instr_reg[25:0], 2'b00};
                end
                default:
                begin
                    npc_next = pc4;
                end
            endcase
        end

        // drop writes to $0
        if (dest_next == '0)
            we_next = 1'b0;

        baddr_ext = 32'(s1_baddr_reg);
        base      = exec ? eff[AW-1:0] : baddr_ext[AW-1:0];
        for (int b = 0; b < BANKS; b++)
        begin
            bank_off[b]  = 2'(2'(b) - base[1:0]);
            bank_addr[b] = base + AW'(bank_off[b]);
            s1_rows[b]   = bank_addr[b][AW-1:2];
        end
    end

    assign dm_rrow_next = s1_adv ? s1_rows : s2_rows_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            pc_reg       <= '0;
            halt_reg     <= 1'b0;
        end
        else
        begin
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;
            if (s1_adv)
            begin
                pc_reg   <= npc_next;
                halt_reg <= halt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg    <= in_op;
            s1_instr_reg <= in_instr;
            s1_baddr_reg <= in_baddr;
            s1_bval_reg  <= in_bval;
            s1_ra_reg    <= ra_next;
            s1_rb_reg    <= rb_next;
        end
    end

    // ---------------- stage 2: memory and write-back ----------------
    always_comb
    begin
        sd_bytes = s2_sdata_reg;
        for (int i = 0; i < BANKS; i++)
        begin
            ld_bytes[2'(3 - i)] = dm_rdata[2'(s2_off_reg + 2'(i))];
        end
        s2_value = s2_load_reg ? ld_bytes : s2_alu_reg;

        if (s2_op_reg == OP_BRD)
            s2_rdval = {24'h000000, dm_rdata[s2_off_reg]};
        else
            s2_rdval = s2_rdval_reg;

        st_idx = '0;
        for (int b = 0; b < BANKS; b++)
        begin
            dm_wr_row[b]  = s2_rows_reg[b];
            dm_wr_en[b]   = 1'b0;
            dm_wr_data[b] = s2_bval_reg;
            if (s2_adv && s2_store_reg)
            begin
                st_idx        = 2'(2'(b) - s2_off_reg);
                dm_wr_en[b]   = 1'b1;
                dm_wr_data[b] = sd_bytes[2'(2'd3 - st_idx)];
            end
            else if (s2_adv && s2_op_reg == OP_BWR && 2'(b) == s2_off_reg)
            begin
                dm_wr_en[b] = 1'b1;
            end
        end

        rf_wr.en   = s2_adv && s2_reg_we_reg;
        rf_wr.addr = s2_dest_reg;
        rf_wr.data = s2_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s1_adv)
            s2_valid_reg <= 1'b1;
        else if (s2_adv)
            s2_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_op_reg     <= s1_op_reg;
            s2_reg_we_reg <= we_next;
            s2_dest_reg   <= we_next ? dest_next : 5'd0;
            s2_alu_reg    <= alu_next;
            s2_load_reg   <= load_next;
            s2_store_reg  <= store_next;
            s2_sdata_reg  <= op_b;
            s2_bval_reg   <= s1_bval_reg;
            s2_off_reg    <= base[1:0];
            s2_rows_reg   <= s1_rows;
            s2_npc_reg    <= npc_next;
            s2_halt_reg   <= halt_next;
            s2_rdval_reg  <= (s1_op_reg == OP_RREG) ? op_a : 32'd0;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (s2_adv)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            m_data_reg <= {s2_rdval,
                           s2_store_reg,
                           s2_reg_we_reg ? s2_value : 32'd0,
                           s2_dest_reg,
                           s2_reg_we_reg,
                           s2_halt_reg,
                           s2_npc_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `MSCC_ASSERT(a_halt_sticky, clk, rst_n, halt_reg |=> halt_reg)
    `MSCC_ASSERT(a_pc_frozen_when_halted, clk, rst_n, halt_reg |=> $stable(pc_reg))
    `MSCC_NEVER(a_no_item_while_clearing, clk, rst_n, dm_busy && (s1_valid_reg || s2_valid_reg))
    `MSCC_NEVER(a_no_write_to_zero, clk, rst_n, rf_wr.en && rf_wr.addr == 5'd0)
    `MSCC_NEVER(a_store_and_regwrite, clk, rst_n, s2_valid_reg && s2_store_reg && s2_reg_we_reg)

endmodule

// ----- rtl/mscc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Read-first on a same-address write. No dependencies.
module mscc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/mscc_regfile.sv -----
// General register file: two RAM copies for two read ports, valid bits
// for the all-zero reset and a bypass of the write made at the last edge.
// Depends on mscc_pkg and mscc_ram.
module mscc_regfile (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [mscc_pkg::REG_AW-1:0]    ra_next,
    input  logic [mscc_pkg::REG_AW-1:0]    rb_next,
    input  mscc_pkg::rf_wr_t               wr,
    output logic [mscc_pkg::WORD_W-1:0]    rdata_a,
    output logic [mscc_pkg::WORD_W-1:0]    rdata_b
);
    import mscc_pkg::*;

    `include "mips_subset_single_cycle_core_macros.svh"

    logic [REG_AW-1:0]    ra_reg;
    logic [REG_AW-1:0]    rb_reg;
    logic [REG_COUNT-1:0] valid_reg;
    logic                 byp_en_reg;
    logic [REG_AW-1:0]    byp_addr_reg;
    logic [WORD_W-1:0]    byp_data_reg;
    logic [WORD_W-1:0]    ram_a;
    logic [WORD_W-1:0]    ram_b;

    mscc_ram #(.WIDTH(WORD_W), .DEPTH(REG_COUNT)) u_ram_a (
        .clk   (clk),
        .we    (wr.en),
        .waddr (wr.addr),
        .wdata (wr.data),
        .raddr (ra_next),
        .rdata (ram_a)
    );

    mscc_ram #(.WIDTH(WORD_W), .DEPTH(REG_COUNT)) u_ram_b (
        .clk   (clk),
        .we    (wr.en),
        .waddr (wr.addr),
        .wdata (wr.data),
        .raddr (rb_next),
        .rdata (ram_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            byp_en_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            byp_en_reg <= wr.en;
        end
    end

    always_ff @(posedge clk)
    begin
        ra_reg       <= ra_next;
        rb_reg       <= rb_next;
        byp_addr_reg <= wr.addr;
        byp_data_reg <= wr.data;
    end

    // the RAM returns the old word when written at the read edge: take the bypass
    always_comb
    begin
        if (byp_en_reg && byp_addr_reg == ra_reg)
            rdata_a = byp_data_reg;
        else if (valid_reg[ra_reg])
            rdata_a = ram_a;
        else
            rdata_a = '0;

        if (byp_en_reg && byp_addr_reg == rb_reg)
            rdata_b = byp_data_reg;
        else if (valid_reg[rb_reg])
            rdata_b = ram_b;
        else
            rdata_b = '0;
    end

    `MSCC_NEVER(a_rf_zero_valid, clk, rst_n, valid_reg[0])
    `MSCC_ASSERT(a_rf_write_sets_valid, clk, rst_n, wr.en |=> valid_reg[$past(wr.addr)])

endmodule

// ----- rtl/mscc_dmem.sv -----
// Byte data memory as four byte-interleaved byte banks, with a clearing
// sweep after reset and a per-bank bypass of the write at the last edge.
// Depends on mscc_pkg and mscc_ram.
module mscc_dmem #(
    parameter int DATA_BYTES = mscc_pkg::DATA_BYTES_DEF,
    localparam int RW = $clog2(DATA_BYTES) - 2
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [mscc_pkg::BANKS-1:0][RW-1:0]  rrow_next,
    input  logic [mscc_pkg::BANKS-1:0]          wr_en,
    input  logic [mscc_pkg::BANKS-1:0][RW-1:0]  wr_row,
    input  logic [mscc_pkg::BANKS-1:0][7:0]     wr_data,
    output logic [mscc_pkg::BANKS-1:0][7:0]     rdata,
    output logic                                busy
);
    import mscc_pkg::*;

    localparam int ROWS = DATA_BYTES / BANKS;

    logic [RW-1:0]             clr_cnt_reg;
    logic                      busy_reg;
    logic [BANKS-1:0]          bank_we;
    logic [BANKS-1:0][RW-1:0]  bank_row;
    logic [BANKS-1:0][7:0]     bank_wdata;
    logic [BANKS-1:0][7:0]     ram_q;
    logic [BANKS-1:0][RW-1:0]  rrow_reg;
    logic [BANKS-1:0]          byp_en_reg;
    logic [BANKS-1:0][RW-1:0]  byp_row_reg;
    logic [BANKS-1:0][7:0]     byp_data_reg;

    // sweep zeros through every row while busy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            busy_reg    <= 1'b1;
        end
        else if (busy_reg)
        begin
            if (clr_cnt_reg == RW'(ROWS - 1))
                busy_reg <= 1'b0;
            else
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    assign busy = busy_reg;

    always_comb
    begin
        for (int b = 0; b < BANKS; b++)
        begin
            bank_we[b]    = busy_reg | wr_en[b];
            bank_row[b]   = busy_reg ? clr_cnt_reg : wr_row[b];
            bank_wdata[b] = busy_reg ? 8'h00 : wr_data[b];
        end
    end

    for (genvar g = 0; g < BANKS; g++)
    begin : g_bank
        mscc_ram #(.WIDTH(8), .DEPTH(ROWS)) u_ram (
            .clk   (clk),
            .we    (bank_we[g]),
            .waddr (bank_row[g]),
            .wdata (bank_wdata[g]),
            .raddr (rrow_next[g]),
            .rdata (ram_q[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byp_en_reg <= '0;
        else
            byp_en_reg <= bank_we;
    end

    always_ff @(posedge clk)
    begin
        rrow_reg     <= rrow_next;
        byp_row_reg  <= bank_row;
        byp_data_reg <= bank_wdata;
    end

    always_comb
    begin
        for (int b = 0; b < BANKS; b++)
        begin
            if (byp_en_reg[b] && byp_row_reg[b] == rrow_reg[b])
                rdata[b] = byp_data_reg[b];
            else
                rdata[b] = ram_q[b];
        end
    end

    `MSCC_NEVER(a_dm_write_while_busy, clk, rst_n, busy_reg && (wr_en != '0))
    `MSCC_ASSERT(a_dm_busy_only_falls, clk, rst_n, !busy_reg |=> !busy_reg)

endmodule
